// ===== hdl/lfu_pkg.sv =====
// Shared types, constants and the key filter for the LFU frequency table.
package lfu_pkg;

  localparam int unsigned KeyW   = 48;
  localparam int unsigned CountW = 31;

  localparam logic [CountW-1:0] CountMax = 31'h7FFF_FFFF;
  localparam logic [CountW-1:0] CountOne = 31'd1;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } slot_t;

  // Search outcome handed from the scan unit to the sequencer.
  typedef struct packed {
    logic match_hit;
    logic free_hit;
  } scan_flags_t;

  // Request kinds carried on the input tuser.
  localparam logic ReqObserve = 1'b0;
  localparam logic ReqAge     = 1'b1;

  // Keys in [0x10000, 2^47) that are 8-aligned are counted.
  function automatic logic key_ok(input logic [KeyW-1:0] key);
    logic above_low;
    logic below_limit;
    logic aligned;
    above_low   = |key[KeyW-2:16];
    below_limit = ~key[KeyW-1];
    aligned     = (key[2:0] == 3'b000);
    return above_low & below_limit & aligned;
  endfunction

endpackage

// ===== hdl/lfu_slot_mem.sv =====
// Slot memory: one write port, one registered read port, per-entry valid flops.
module lfu_slot_mem
  import lfu_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [$clog2(SLOTS)-1:0]  waddr_i,
  input  slot_t                     wdata_i,
  input  logic [$clog2(SLOTS)-1:0]  raddr_i,
  output logic                      rd_vld_o,
  output slot_t                     rd_data_o
);

  logic [SLOTS-1:0] valid_q;
  slot_t            mem_q [SLOTS];
  slot_t            rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem_q[raddr_i];
  end

  // An entry never written reads as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  assign rd_vld_o  = rd_vld_q;
  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/lfu_scan_unit.sv =====
// Scan unit: comparators on one count reference, trackers, one slot per enabled cycle.
module lfu_scan_unit
  import lfu_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      en_i,
  input  logic                      hot_mode_i,
  input  logic [$clog2(SLOTS)-1:0]  idx_i,
  input  logic                      slot_vld_i,
  input  slot_t                     slot_i,
  input  logic [KeyW-1:0]           req_key_i,
  output scan_flags_t               flags_o,
  output logic [$clog2(SLOTS)-1:0]  match_idx_o,
  output logic [CountW-1:0]         match_cnt_o,
  output logic [$clog2(SLOTS)-1:0]  free_idx_o,
  output logic [$clog2(SLOTS)-1:0]  low_idx_o,
  output logic [KeyW-1:0]           low_key_o,
  output logic [KeyW-1:0]           best_key_o,
  output logic [CountW-1:0]         best_cnt_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  logic              match_hit_q;
  logic [IW-1:0]     match_idx_q;
  logic [CountW-1:0] match_cnt_q;
  logic              free_hit_q;
  logic [IW-1:0]     free_idx_q;
  logic [CountW-1:0] low_cnt_q;
  logic [IW-1:0]     low_idx_q;
  logic [KeyW-1:0]   low_key_q;
  logic [CountW-1:0] best_cnt_q;
  logic [KeyW-1:0]   best_key_q;

  logic [CountW-1:0] cmp_ref;
  logic              cnt_lt;
  logic              cnt_gt;
  logic              key_eq;

  // One shared reference count serves the lowest-count search and the hottest search.
  assign cmp_ref = hot_mode_i ? best_cnt_q : low_cnt_q;
  assign cnt_lt  = slot_i.count < cmp_ref;
  assign cnt_gt  = slot_i.count > cmp_ref;
  assign key_eq  = slot_i.key == req_key_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_hit_q <= 1'b0;
      match_idx_q <= '0;
      match_cnt_q <= '0;
      free_hit_q  <= 1'b0;
      free_idx_q  <= '0;
      low_cnt_q   <= CountMax;
      low_idx_q   <= '0;
      low_key_q   <= '0;
      best_cnt_q  <= '0;
      best_key_q  <= '0;
    end else if (clr_i) begin
      match_hit_q <= 1'b0;
      match_idx_q <= '0;
      match_cnt_q <= '0;
      free_hit_q  <= 1'b0;
      free_idx_q  <= '0;
      low_cnt_q   <= CountMax;
      low_idx_q   <= '0;
      low_key_q   <= '0;
      best_cnt_q  <= '0;
      best_key_q  <= '0;
    end else if (en_i) begin
      if (hot_mode_i) begin
        if (slot_vld_i && cnt_gt) begin
          best_cnt_q <= slot_i.count;
          best_key_q <= slot_i.key;
        end
      end else begin
        if (slot_vld_i && key_eq && !match_hit_q) begin
          match_hit_q <= 1'b1;
          match_idx_q <= idx_i;
          match_cnt_q <= slot_i.count;
        end
        if (!slot_vld_i) begin
          if (!free_hit_q) begin
            free_hit_q <= 1'b1;
            free_idx_q <= idx_i;
          end
        end else if (cnt_lt || (idx_i == '0)) begin
          // slot 0 stays the victim when every count sits at the maximum
          low_cnt_q <= slot_i.count;
          low_idx_q <= idx_i;
          low_key_q <= slot_i.key;
        end
      end
    end
  end

  assign flags_o.match_hit = match_hit_q;
  assign flags_o.free_hit  = free_hit_q;
  assign match_idx_o       = match_idx_q;
  assign match_cnt_o       = match_cnt_q;
  assign free_idx_o        = free_idx_q;
  assign low_idx_o         = low_idx_q;
  assign low_key_o         = low_key_q;
  assign best_key_o        = best_key_q;
  assign best_cnt_o        = best_cnt_q;

endmodule

// ===== hdl/lfu_frequency_table_core.sv =====
// LFU frequency table top level: stream ports, sequencer and output register.
//
// One word is taken at a time; s_axis_tready is low until the result word has
// been taken. The slot memory has a single read port that a sequencer walks one
// slot per cycle: an observe word with a counted key costs a search pass, a table
// write and a hottest-slot pass; an age word costs a read-modify-write pass and
// the hottest pass; a filtered key costs only the hottest pass. The table is
// empty right after reset with no clearing pass.
// Result tuser holds {evicted, key_accepted}; tdata holds evicted_key,
// hottest_key and hottest_count.
module lfu_frequency_table_core
  import lfu_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // [47:0] key
  input  logic         s_axis_tuser,  // [0] req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // [47:0] evicted_key, [95:48] hottest_key,
                                      // [126:96] hottest_count, [127] zero
  output logic [1:0]   m_axis_tuser   // [0] key_accepted, [1] evicted
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW:0] SlotsC = (IW+1)'(SLOTS);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSearch = 6'b000010,
    StUpdate = 6'b000100,
    StAge    = 6'b001000,
    StHot    = 6'b010000,
    StOut    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [KeyW-1:0]   key_q;
  logic [IW:0]       cnt_q;
  logic              pipe_vld_q;
  logic [IW-1:0]     pipe_idx_q;

  logic              out_acc_q;
  logic              out_ev_q;
  logic [KeyW-1:0]   out_evk_q;
  logic [KeyW-1:0]   out_hkey_q;
  logic [CountW-1:0] out_hcnt_q;

  logic              s_fire;
  logic              m_fire;
  logic              scan_state;
  logic              issuing;
  logic              scan_done;
  logic              clr;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic              rd_vld;
  slot_t             rd_data;

  scan_flags_t       flags;
  logic [IW-1:0]     match_idx;
  logic [CountW-1:0] match_cnt;
  logic [IW-1:0]     free_idx;
  logic [IW-1:0]     low_idx;
  logic [KeyW-1:0]   low_key;
  logic [KeyW-1:0]   best_key;
  logic [CountW-1:0] best_cnt;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign m_fire     = m_axis_tvalid && m_axis_tready;
  assign scan_state = (state_q == StSearch) || (state_q == StAge) || (state_q == StHot);
  assign issuing    = scan_state && (cnt_q != SlotsC);
  assign scan_done  = (cnt_q == SlotsC) && !pipe_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (s_axis_tuser == ReqAge) begin
            state_d = StAge;
          end else if (key_ok(s_axis_tdata)) begin
            state_d = StSearch;
          end else begin
            state_d = StHot;
          end
        end
      end
      StSearch: begin
        if (scan_done) state_d = StUpdate;
      end
      StUpdate: begin
        state_d = StHot;
      end
      StAge: begin
        if (scan_done) state_d = StHot;
      end
      StHot: begin
        if (scan_done) state_d = StOut;
      end
      StOut: begin
        if (m_fire) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Restart the walk and the trackers on entry to any scan pass.
  assign clr = (state_d != state_q) &&
               ((state_d == StSearch) || (state_d == StAge) || (state_d == StHot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      pipe_vld_q <= 1'b0;
      pipe_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      pipe_vld_q <= issuing;
      pipe_idx_q <= cnt_q[IW-1:0];
      if (clr) begin
        cnt_q <= '0;
      end else if (issuing) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Write port: table update after a search, halving during the age pass.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pipe_idx_q;
    mem_wdata = rd_data;
    if (state_q == StUpdate) begin
      mem_we        = 1'b1;
      mem_wdata.key = key_q;
      if (flags.match_hit) begin
        mem_waddr       = match_idx;
        mem_wdata.count = (match_cnt == CountMax) ? CountMax : match_cnt + CountOne;
      end else begin
        mem_waddr       = flags.free_hit ? free_idx : low_idx;
        mem_wdata.count = CountOne;
      end
    end else if (state_q == StAge) begin
      mem_we          = pipe_vld_q && rd_vld && (rd_data.count > CountOne);
      mem_wdata.count = rd_data.count >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      out_acc_q  <= 1'b0;
      out_ev_q   <= 1'b0;
      out_evk_q  <= '0;
      out_hkey_q <= '0;
      out_hcnt_q <= '0;
    end else begin
      if (s_fire) begin
        key_q     <= s_axis_tdata;
        out_acc_q <= (s_axis_tuser == ReqObserve) && key_ok(s_axis_tdata);
        out_ev_q  <= 1'b0;
        out_evk_q <= '0;
      end
      if ((state_q == StUpdate) && !flags.match_hit && !flags.free_hit) begin
        out_ev_q  <= 1'b1;
        out_evk_q <= low_key;
      end
      if ((state_q == StHot) && scan_done) begin
        out_hkey_q <= best_key;
        out_hcnt_q <= best_cnt;
      end
    end
  end

  lfu_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_i   (cnt_q[IW-1:0]),
    .rd_vld_o  (rd_vld),
    .rd_data_o (rd_data)
  );

  lfu_scan_unit #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (clr),
    .en_i        (pipe_vld_q && ((state_q == StSearch) || (state_q == StHot))),
    .hot_mode_i  (state_q == StHot),
    .idx_i       (pipe_idx_q),
    .slot_vld_i  (rd_vld),
    .slot_i      (rd_data),
    .req_key_i   (key_q),
    .flags_o     (flags),
    .match_idx_o (match_idx),
    .match_cnt_o (match_cnt),
    .free_idx_o  (free_idx),
    .low_idx_o   (low_idx),
    .low_key_o   (low_key),
    .best_key_o  (best_key),
    .best_cnt_o  (best_cnt)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {1'b0, out_hcnt_q, out_hkey_q, out_evk_q};
  assign m_axis_tuser  = {out_ev_q, out_acc_q};

  // Input and output never open in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // An eviction only follows an accepted key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("eviction without an accepted key");

  // A hottest slot is reported with a nonzero count exactly when its key is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_hcnt_q == '0) == (out_hkey_q == '0)))
    else $error("hottest key and count disagree on an empty table");

  // A counted observe leaves at least one occupied slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (out_hcnt_q != '0))
    else $error("empty table after an accepted key");

  // The walk counter never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SlotsC)
    else $error("slot walk overran the table");

endmodule

// ===== dv/tb_lfu_frequency_table_core.sv =====
// Testbench for the LFU frequency table core: stream stimulus and table scoreboard.
module tb_lfu_frequency_table_core
  import lfu_pkg::*;
;

  localparam int unsigned TableSlots  = 32;
  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 2 * TableSlots + 20;
  localparam int unsigned PoolSize    = 48;
  localparam int unsigned HotKeys     = 10;
  localparam int unsigned PhaseWords  = 183;

  localparam logic [KeyW-1:0] KeyFloor = 48'h0000_0001_0000;
  localparam logic [KeyW-1:0] KeyCeil  = 48'h8000_0000_0000;
  localparam logic [KeyW-1:0] KeyOnes  = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic              accepted;
    logic              evicted;
    logic [KeyW-1:0]   evicted_key;
    logic [KeyW-1:0]   hottest_key;
    logic [CountW-1:0] hottest_count;
  } lfu_result_t;

  // Mirror of the slot table plus the queue of results still owed by the core.
  class lfu_scoreboard;
    logic [KeyW-1:0]   slot_key[TableSlots];
    logic [CountW-1:0] slot_cnt[TableSlots];
    lfu_result_t       owed[$];
    int unsigned       mismatches;

    function new();
      for (int i = 0; i < TableSlots; i++) begin
        slot_key[i] = '0;
        slot_cnt[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void note_word(logic req, logic [KeyW-1:0] key);
      lfu_result_t       res;
      int                free_at;
      int                low_at;
      int                hit_at;
      logic [CountW-1:0] low;
      res = '{1'b0, 1'b0, '0, '0, '0};
      if (req == ReqAge) begin
        for (int i = 0; i < TableSlots; i++)
          if (slot_cnt[i] > CountOne) slot_cnt[i] = slot_cnt[i] >> 1;
      end else if (key >= KeyFloor && key < KeyCeil && key[2:0] == 3'b000) begin
        res.accepted = 1'b1;
        hit_at = -1;
        for (int i = 0; i < TableSlots; i++)
          if (hit_at < 0 && slot_key[i] == key) hit_at = i;
        if (hit_at >= 0) begin
          if (slot_cnt[hit_at] < CountMax) slot_cnt[hit_at] = slot_cnt[hit_at] + CountOne;
        end else begin
          free_at = -1;
          low_at  = 0;
          low     = CountMax;
          for (int i = 0; i < TableSlots; i++) begin
            if (slot_key[i] == '0) begin
              if (free_at < 0) free_at = i;
            end else if (slot_cnt[i] < low) begin
              low    = slot_cnt[i];
              low_at = i;
            end
          end
          if (free_at < 0) begin
            // table full: give up the first slot with the lowest count
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[low_at];
            free_at         = low_at;
          end
          slot_key[free_at] = key;
          slot_cnt[free_at] = CountOne;
        end
      end
      for (int i = 0; i < TableSlots; i++) begin
        if (slot_key[i] != '0 && slot_cnt[i] > res.hottest_count) begin
          res.hottest_count = slot_cnt[i];
          res.hottest_key   = slot_key[i];
        end
      end
      owed.push_back(res);
    endfunction

    function void compare_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %h, actual %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(logic [1:0] user, logic [127:0] data);
      lfu_result_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing outstanding: tuser %h tdata %h", user, data);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      compare_field("key_accepted", KeyW'(want.accepted), KeyW'(user[0]));
      compare_field("evicted", KeyW'(want.evicted), KeyW'(user[1]));
      compare_field("evicted_key", want.evicted_key, data[47:0]);
      compare_field("hottest_key", want.hottest_key, data[95:48]);
      compare_field("hottest_count", KeyW'(want.hottest_count), KeyW'(data[126:96]));
      compare_field("tdata_pad", '0, KeyW'(data[127]));
    endfunction
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata  = '0;
  logic         s_axis_tuser  = ReqObserve;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  lfu_scoreboard   sb = new();
  int unsigned     tx_idle_pct  = 0;
  int unsigned     rx_stall_pct = 0;
  int unsigned     quiet_cycles = 0;
  logic [KeyW-1:0] key_pool[PoolSize];

  lfu_frequency_table_core #(
    .SLOTS(TableSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Note accepted inputs before checking results, all from one process.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tuser, m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Entered and left at a falling edge; one assignment per signal per edge.
  task automatic send_word(logic req, logic [KeyW-1:0] key);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    int unsigned     roll;
    logic [KeyW-1:0] key;
    roll = $urandom_range(0, 99);
    key  = KeyW'({$urandom(), $urandom()});
    if (roll < 6) begin
      send_word(ReqAge, key);
    end else if (roll < 12) begin
      send_word(ReqObserve, key);
    end else if (roll < 16) begin
      send_word(ReqObserve, KeyW'($urandom_range(0, 'hFFFF)));
    end else if (roll < 19) begin
      // aligned and in range except for the top bit
      send_word(ReqObserve, {1'b1, key[46:3], 3'b000});
    end else if ($urandom_range(0, 2) == 0) begin
      send_word(ReqObserve, key_pool[$urandom_range(0, PoolSize - 1)]);
    end else begin
      // skew toward a few keys so counts climb and ties appear
      send_word(ReqObserve, key_pool[$urandom_range(0, HotKeys - 1)]);
    end
  endtask

  initial begin
    logic [KeyW-1:0] key;
    for (int i = 0; i < PoolSize; i++) begin
      key = KeyW'({$urandom(), $urandom()});
      key = {1'b0, key[46:3], 3'b000};
      if (key < KeyFloor) key[20] = 1'b1;
      key_pool[i] = key;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(ReqAge, '0);
    send_word(ReqObserve, '0);
    send_word(ReqObserve, KeyFloor - 48'd8);
    send_word(ReqObserve, KeyFloor + 48'd1);
    send_word(ReqObserve, KeyCeil);
    send_word(ReqObserve, KeyOnes);
    send_word(ReqObserve, KeyFloor);
    send_word(ReqObserve, KeyCeil - 48'd8);
    send_word(ReqObserve, KeyCeil - 48'd8);
    send_word(ReqObserve, KeyFloor);
    send_word(ReqObserve, KeyFloor);
    send_word(ReqObserve, KeyFloor + 48'd4);
    send_word(ReqAge, KeyOnes);
    send_word(ReqAge, '0);
    send_word(ReqObserve, 48'h5555_5555_5550);
    send_word(ReqObserve, 48'h2AAA_AAAA_AAA8);
    send_word(ReqObserve, 48'h2AAA_AAAA_AAA8);
    send_word(ReqObserve, 48'h7FFF_FFFF_FFFF);
    send_word(ReqAge, 48'h5555_5555_5555);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      repeat (PhaseWords) send_random_word();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lfu_pkg.sv
hdl/lfu_slot_mem.sv
hdl/lfu_scan_unit.sv
hdl/lfu_frequency_table_core.sv
dv/tb_lfu_frequency_table_core.sv
